### rtl/mwc_hs_pkg.sv
// ----------------------------------------------------------------------------
// mwc_hs_pkg
// Types, constants and the control store of the MWC generator sequencer.
// ----------------------------------------------------------------------------
package mwc_hs_pkg;

  localparam logic [31:0] MWC_MULT  = 32'hffffda61;
  localparam logic [63:0] FOLD_MULT = 64'd1037;
  localparam logic [63:0] ZERO_SUB  = 64'h5a17;
  localparam logic [63:0] MIX_M1    = 64'd265;
  localparam logic [63:0] MIX_M2    = 64'd21;
  localparam int unsigned MIX_S0    = 21;
  localparam int unsigned MIX_S1    = 24;
  localparam int unsigned MIX_S2    = 14;
  localparam int unsigned MIX_S3    = 28;
  localparam int unsigned MIX_S4    = 31;

  typedef logic [3:0] addr_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_PRE   = 4'd0,  // v = ~v + (v << 21)
    OP_XS24  = 4'd1,
    OP_M265  = 4'd2,
    OP_XS14  = 4'd3,
    OP_M21   = 4'd4,
    OP_XS28  = 4'd5,
    OP_ADD31 = 4'd6,
    OP_FOLD  = 4'd7,  // v = acc * 1037 ^ v
    OP_KEEP  = 4'd8,  // acc = v
    OP_LOAD  = 4'd9,  // gen = v (zero substituted), acc = 0
    OP_MWC   = 4'd10  // one generator advance
  } op_e;

  typedef enum logic [0:0] {
    COND_NONE = 1'b0,
    COND_LAST = 1'b1
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    addr_t target;
    logic  done;
  } ctrl_word_t;

  localparam addr_t ADDR_FOLD = 4'd0;
  localparam addr_t ADDR_KEEP = 4'd8;
  localparam addr_t ADDR_LOAD = 4'd9;
  localparam addr_t ADDR_ADV  = 4'd10;

  function automatic ctrl_word_t rom_word(addr_t a);
    ctrl_word_t w;
    w = '{op: OP_MWC, cond: COND_NONE, target: ADDR_FOLD, done: 1'b1};
    case (a)
      4'd0:    w = '{op: OP_PRE,   cond: COND_NONE, target: ADDR_FOLD, done: 1'b0};
      4'd1:    w = '{op: OP_XS24,  cond: COND_NONE, target: ADDR_FOLD, done: 1'b0};
      4'd2:    w = '{op: OP_M265,  cond: COND_NONE, target: ADDR_FOLD, done: 1'b0};
      4'd3:    w = '{op: OP_XS14,  cond: COND_NONE, target: ADDR_FOLD, done: 1'b0};
      4'd4:    w = '{op: OP_M21,   cond: COND_NONE, target: ADDR_FOLD, done: 1'b0};
      4'd5:    w = '{op: OP_XS28,  cond: COND_NONE, target: ADDR_FOLD, done: 1'b0};
      4'd6:    w = '{op: OP_ADD31, cond: COND_NONE, target: ADDR_FOLD, done: 1'b0};
      4'd7:    w = '{op: OP_FOLD,  cond: COND_LAST, target: ADDR_LOAD, done: 1'b0};
      4'd8:    w = '{op: OP_KEEP,  cond: COND_NONE, target: ADDR_FOLD, done: 1'b1};
      4'd9:    w = '{op: OP_LOAD,  cond: COND_NONE, target: ADDR_FOLD, done: 1'b1};
      4'd10:   w = '{op: OP_MWC,   cond: COND_NONE, target: ADDR_FOLD, done: 1'b1};
      default: w = '{op: OP_MWC,   cond: COND_NONE, target: ADDR_FOLD, done: 1'b1};
    endcase
    return w;
  endfunction

endpackage

### rtl/mwc_hs_if.sv
// ----------------------------------------------------------------------------
// mwc_hs_if
// Request and response channels of the MWC generator.
// ----------------------------------------------------------------------------
interface mwc_hs_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] seed_chunk;
  logic        last_chunk;

  modport source (output valid, action, seed_chunk, last_chunk, input ready);
  modport sink (input valid, action, seed_chunk, last_chunk, output ready);
endinterface

interface mwc_hs_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] state_low;
  logic [31:0] state_high;

  modport source (output valid, state_low, state_high, input ready);
  modport sink (input valid, state_low, state_high, output ready);
endinterface

### rtl/mwc_hs_seq.sv
// ----------------------------------------------------------------------------
// mwc_hs_seq
// Step counter and control store; one control word per cycle unless held.
// ----------------------------------------------------------------------------
module mwc_hs_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   action_i,
  input  logic                   last_i,
  input  logic                   hold_i,
  output logic                   busy_o,
  output mwc_hs_pkg::ctrl_word_t ctrl_o
);

  logic              busy_q;
  mwc_hs_pkg::addr_t pc_q;
  logic              last_q;

  assign ctrl_o = mwc_hs_pkg::rom_word(pc_q);
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= mwc_hs_pkg::ADDR_FOLD;
      last_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pc_q   <= action_i ? mwc_hs_pkg::ADDR_ADV : mwc_hs_pkg::ADDR_FOLD;
      last_q <= last_i;
    end else if (busy_q && !hold_i) begin
      if (ctrl_o.done) begin
        busy_q <= 1'b0;
      end else if (ctrl_o.cond == mwc_hs_pkg::COND_LAST && last_q) begin
        pc_q <= ctrl_o.target;
      end else begin
        pc_q <= pc_q + 4'd1;
      end
    end
  end

endmodule

### rtl/mwc_random_with_hashed_seed_core.sv
// ----------------------------------------------------------------------------
// mwc_random_with_hashed_seed_core
// Multiply-with-carry generator with a hashed 64-bit seed accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: action 0 folds seed_chunk into the seed
//   accumulator (last_chunk 1 loads the generator from it), action 1
//   advances the generator one step. Every request yields exactly one
//   response on rsp_o with the generator words after that request.
// Timing:
//   A microcoded sequencer executes one control word per cycle unless the
//   final step is held. A fold runs 9 steps (mix chain, fold, then store to
//   the accumulator or load the generator). An advance is one step (32x32
//   multiply-add). A new request is taken only after the final step of the
//   previous one has executed.
// Reset:
//   Accumulator and generator words clear to zero, no response pending.
// Stall:
//   The response is held in an output register. A request is accepted
//   while a response waits; its final step holds until that response is
//   taken.
// ----------------------------------------------------------------------------
module mwc_random_with_hashed_seed_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  mwc_hs_req_if.sink   req_i,
  mwc_hs_rsp_if.source rsp_o
);

  mwc_hs_pkg::ctrl_word_t ctrl;
  logic                   busy;
  logic                   hold;
  logic                   exec;
  logic                   start;

  logic [63:0] v_q, v_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] gen_low_q, gen_low_d;
  logic [31:0] gen_high_q, gen_high_d;
  logic [63:0] mwc_t;
  logic        rsp_valid_q;
  logic [31:0] rsp_low_q;
  logic [31:0] rsp_high_q;

  assign req_i.ready = !busy;
  assign start       = req_i.valid && !busy;
  assign hold        = ctrl.done && rsp_valid_q && !rsp_o.ready;
  assign exec        = busy && !hold;

  mwc_hs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (req_i.action),
    .last_i   (req_i.last_chunk),
    .hold_i   (hold),
    .busy_o   (busy),
    .ctrl_o   (ctrl)
  );

  always_comb begin
    v_d        = v_q;
    acc_d      = acc_q;
    gen_low_d  = gen_low_q;
    gen_high_d = gen_high_q;
    mwc_t      = {32'd0, gen_low_q} * {32'd0, mwc_hs_pkg::MWC_MULT} + {32'd0, gen_high_q};
    case (ctrl.op)
      mwc_hs_pkg::OP_PRE:   v_d = ~v_q + (v_q << mwc_hs_pkg::MIX_S0);
      mwc_hs_pkg::OP_XS24:  v_d = v_q ^ (v_q >> mwc_hs_pkg::MIX_S1);
      mwc_hs_pkg::OP_M265:  v_d = v_q * mwc_hs_pkg::MIX_M1;
      mwc_hs_pkg::OP_XS14:  v_d = v_q ^ (v_q >> mwc_hs_pkg::MIX_S2);
      mwc_hs_pkg::OP_M21:   v_d = v_q * mwc_hs_pkg::MIX_M2;
      mwc_hs_pkg::OP_XS28:  v_d = v_q ^ (v_q >> mwc_hs_pkg::MIX_S3);
      mwc_hs_pkg::OP_ADD31: v_d = v_q + (v_q << mwc_hs_pkg::MIX_S4);
      mwc_hs_pkg::OP_FOLD:  v_d = (acc_q * mwc_hs_pkg::FOLD_MULT) ^ v_q;
      mwc_hs_pkg::OP_KEEP:  acc_d = v_q;
      mwc_hs_pkg::OP_LOAD: begin
        acc_d = '0;
        if (v_q == 64'd0) begin
          gen_low_d  = mwc_hs_pkg::ZERO_SUB[31:0];
          gen_high_d = mwc_hs_pkg::ZERO_SUB[63:32];
        end else begin
          gen_low_d  = v_q[31:0];
          gen_high_d = v_q[63:32];
        end
      end
      mwc_hs_pkg::OP_MWC: begin
        gen_low_d  = mwc_t[31:0];
        gen_high_d = mwc_t[63:32];
      end
      default: v_d = v_q;
    endcase
  end

  // working register: takes the chunk on acceptance
  always_ff @(posedge clk_i) begin
    if (start) begin
      v_q <= req_i.seed_chunk;
    end else if (exec) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      gen_low_q  <= '0;
      gen_high_q <= '0;
    end else if (exec) begin
      acc_q      <= acc_d;
      gen_low_q  <= gen_low_d;
      gen_high_q <= gen_high_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (exec && ctrl.done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && ctrl.done) begin
      rsp_low_q  <= gen_low_d;
      rsp_high_q <= gen_high_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.state_low  = rsp_low_q;
  assign rsp_o.state_high = rsp_high_q;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("sequencer not busy after request accepted");

  a_load_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && ctrl.op == mwc_hs_pkg::OP_LOAD) |=> (acc_q == 64'd0))
    else $error("accumulator not cleared on seed load");

  a_load_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && ctrl.op == mwc_hs_pkg::OP_LOAD) |=> (gen_low_q != 32'd0 || gen_high_q != 32'd0))
    else $error("generator loaded with all-zero state");

  a_done_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && ctrl.done) |=> (rsp_o.valid && !busy))
    else $error("final step did not produce a response");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |=> ($stable(gen_low_q) && $stable(gen_high_q) && $stable(acc_q)))
    else $error("state changed while response stalled");
`endif

endmodule

### tb/mwc_random_with_hashed_seed_core_tb.sv
// ----------------------------------------------------------------------------
// mwc_random_with_hashed_seed_core_tb
// Self-checking testbench for the hashed-seed multiply-with-carry generator.
// Directed requests cover the reset state, chunk extremes, the zero-hash
// substitution and advances inside a seeding run. Random seeding runs with
// trailing advances, plus some noise, follow. Sender gaps and response stalls
// vary per phase. A local predictor checks every response word.
// ----------------------------------------------------------------------------
module mwc_random_with_hashed_seed_core_tb;

  localparam logic ACT_FOLD    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [31:0] state_high;
    logic [31:0] state_low;
  } gen_words_t;

  logic clk;
  logic rst_n;

  mwc_hs_req_if req_if ();
  mwc_hs_rsp_if rsp_if ();

  mwc_random_with_hashed_seed_core DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // predictor state
  logic [63:0] seed_acc;
  logic [31:0] gen_lo;
  logic [31:0] gen_hi;
  gen_words_t  expected_words[$];

  int mismatches;
  int n_checked;
  int n_folds;
  int n_loads;
  int n_zero_loads;
  int n_advances;
  int cycle_count;

  int gap_max;
  int stall_max;
  int burst_left;
  int hold_left;
  bit acc_clear;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // 64-bit integer mix applied to each seed chunk
  function automatic logic [63:0] hash_word(logic [63:0] v);
    v = ~v + (v << mwc_hs_pkg::MIX_S0);
    v = v ^ (v >> mwc_hs_pkg::MIX_S1);
    v = v * mwc_hs_pkg::MIX_M1;
    v = v ^ (v >> mwc_hs_pkg::MIX_S2);
    v = v * mwc_hs_pkg::MIX_M2;
    v = v ^ (v >> mwc_hs_pkg::MIX_S3);
    v = v + (v << mwc_hs_pkg::MIX_S4);
    return v;
  endfunction

  function automatic logic [63:0] odd_inverse(logic [63:0] a);
    logic [63:0] inv;
    inv = a;
    repeat (5) inv = inv * (64'd2 - a * inv);
    return inv;
  endfunction

  function automatic logic [63:0] undo_xorshift(logic [63:0] y, int unsigned s);
    logic [63:0] x;
    x = y;
    for (int k = 0; k <= 64 / s; k++) x = y ^ (x >> s);
    return x;
  endfunction

  // chunk whose mix is v; used to hit a zero accumulator on purpose
  function automatic logic [63:0] unhash_word(logic [63:0] v);
    v = v * odd_inverse(64'd1 + (64'd1 << mwc_hs_pkg::MIX_S4));
    v = undo_xorshift(v, mwc_hs_pkg::MIX_S3);
    v = v * odd_inverse(mwc_hs_pkg::MIX_M2);
    v = undo_xorshift(v, mwc_hs_pkg::MIX_S2);
    v = v * odd_inverse(mwc_hs_pkg::MIX_M1);
    v = undo_xorshift(v, mwc_hs_pkg::MIX_S1);
    v = (v + 64'd1) * odd_inverse((64'd1 << mwc_hs_pkg::MIX_S0) - 64'd1);
    return v;
  endfunction

  function automatic void update_generator(logic act, logic [63:0] chunk, logic is_last);
    logic [63:0] acc;
    logic [63:0] prod;
    if (act == ACT_ADVANCE) begin
      prod = {32'h0, mwc_hs_pkg::MWC_MULT} * {32'h0, gen_lo} + {32'h0, gen_hi};
      gen_lo = prod[31:0];
      gen_hi = prod[63:32];
      n_advances++;
    end else begin
      acc = (seed_acc * mwc_hs_pkg::FOLD_MULT) ^ hash_word(chunk);
      n_folds++;
      if (is_last) begin
        if (acc == 64'h0) begin
          acc = mwc_hs_pkg::ZERO_SUB;
          n_zero_loads++;
        end
        gen_lo   = acc[31:0];
        gen_hi   = acc[63:32];
        seed_acc = 64'h0;
        n_loads++;
      end else begin
        seed_acc = acc;
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h (response %0d)", what, got, want,
             n_checked);
    mismatches++;
  endtask

  // request monitor feeds the predictor, response monitor checks
  always @(posedge clk) begin
    gen_words_t want;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        update_generator(req_if.action, req_if.seed_chunk, req_if.last_chunk);
        expected_words.push_back('{state_high: gen_hi, state_low: gen_lo});
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected response", rsp_if.state_low, 32'h0);
        end else begin
          want = expected_words.pop_front();
          if (rsp_if.state_low !== want.state_low)
            report_mismatch("state_low", rsp_if.state_low, want.state_low);
          if (rsp_if.state_high !== want.state_high)
            report_mismatch("state_high", rsp_if.state_high, want.state_high);
        end
        n_checked++;
      end
    end
  end

  // response stalls: ready runs and stall runs of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (stall_max == 0 || !rsp_if.ready) begin
      rsp_if.ready <= 1'b1;
      hold_left = $urandom_range(0, 7);
    end else begin
      rsp_if.ready <= 1'b0;
      hold_left = $urandom_range(0, stall_max - 1);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               expected_words.size());
      $display("mwc_random_with_hashed_seed_core_tb: FAIL");
      $finish;
    end
  end

  task automatic send_request(logic act, logic [63:0] chunk, logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.seed_chunk <= chunk;
    req_if.last_chunk <= is_last;
    do @(posedge clk); while (!req_if.ready);
    if (act == ACT_FOLD) acc_clear = is_last;
  endtask

  function automatic logic [63:0] pick_chunk();
    case ($urandom_range(0, 7))
      0:       return 64'($urandom_range(0, 255));
      1:       return 64'd1 << $urandom_range(0, 63);
      2:       return ~(64'd1 << $urandom_range(0, 63));
      3:       return $urandom_range(0, 1) ? 64'hffff_ffff_ffff_ffff : 64'h0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_reset_state();
    send_request(ACT_ADVANCE, 64'h0, 1'b0);
    send_request(ACT_ADVANCE, 64'h0, 1'b0);
    send_request(ACT_ADVANCE, 64'hffff_ffff_ffff_ffff, 1'b1);
  endtask

  task automatic test_seed_extremes();
    send_request(ACT_FOLD, 64'h0, 1'b1);
    send_request(ACT_ADVANCE, 64'h0, 1'b0);
    send_request(ACT_FOLD, 64'hffff_ffff_ffff_ffff, 1'b1);
    send_request(ACT_ADVANCE, 64'h0, 1'b0);
    // generator words both all ones: widest multiply-add
    send_request(ACT_FOLD, unhash_word(64'hffff_ffff_ffff_ffff), 1'b1);
    send_request(ACT_ADVANCE, 64'h0, 1'b0);
    send_request(ACT_ADVANCE, 64'h0, 1'b0);
  endtask

  task automatic test_zero_hash();
    logic [63:0] first;
    first = 64'h0123_4567_89ab_cdef;
    send_request(ACT_FOLD, unhash_word(64'h0), 1'b1);
    send_request(ACT_ADVANCE, 64'h0, 1'b0);
    send_request(ACT_FOLD, first, 1'b0);
    send_request(ACT_FOLD, unhash_word(hash_word(first) * mwc_hs_pkg::FOLD_MULT), 1'b1);
    // accumulator stays zero through an unmarked chunk
    send_request(ACT_FOLD, unhash_word(64'h0), 1'b0);
    send_request(ACT_FOLD, 64'h1, 1'b1);
  endtask

  task automatic test_seeding_interleave();
    send_request(ACT_FOLD, 64'hdead_beef_cafe_f00d, 1'b0);
    send_request(ACT_ADVANCE, 64'h5555_5555_5555_5555, 1'b1);
    send_request(ACT_ADVANCE, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_request(ACT_FOLD, 64'h8000_0000_0000_0000, 1'b1);
    send_request(ACT_ADVANCE, 64'h0, 1'b0);
  endtask

  task automatic test_random_traffic(int n, int gap, int stall);
    int sent;
    int chunks;
    int steps;
    logic [63:0] first;
    sent      = 0;
    gap_max   = gap;
    stall_max = stall;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        if (acc_clear && $urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1)) begin
            send_request(ACT_FOLD, unhash_word(64'h0), 1'b1);
            sent++;
          end else begin
            first = pick_chunk();
            send_request(ACT_FOLD, first, 1'b0);
            send_request(ACT_FOLD,
                         unhash_word(hash_word(first) * mwc_hs_pkg::FOLD_MULT), 1'b1);
            sent += 2;
          end
        end else begin
          chunks = $urandom_range(1, 4);
          for (int i = 0; i < chunks; i++) begin
            if (i > 0 && $urandom_range(0, 5) == 0) begin
              send_request(ACT_ADVANCE, pick_chunk(), 1'($urandom));
              sent++;
            end
            send_request(ACT_FOLD, pick_chunk(), i == chunks - 1);
            sent++;
          end
        end
        steps = $urandom_range(0, 8);
        repeat (steps) send_request(ACT_ADVANCE, pick_chunk(), 1'($urandom));
        sent += steps;
      end else begin
        steps = $urandom_range(1, 4);
        repeat (steps) send_request(1'($urandom), pick_chunk(), 1'($urandom));
        sent += steps;
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_FOLD;
    req_if.seed_chunk = 64'h0;
    req_if.last_chunk = 1'b0;
    seed_acc          = 64'h0;
    gen_lo            = 32'h0;
    gen_hi            = 32'h0;
    mismatches        = 0;
    n_checked         = 0;
    n_folds           = 0;
    n_loads           = 0;
    n_zero_loads      = 0;
    n_advances        = 0;
    cycle_count       = 0;
    burst_left        = 0;
    acc_clear         = 1'b1;
    gap_max           = 3;
    stall_max         = 4;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_seed_extremes();
    test_zero_hash();
    test_seeding_interleave();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 6, 0);
    test_random_traffic(400, 0, 12);
    test_random_traffic(400, 10, 20);

    req_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d responses over %0d cycles", n_checked, cycle_count);
    $display("seed chunks %0d, loads %0d (zero hash %0d), advances %0d, mismatches %0d",
             n_folds, n_loads, n_zero_loads, n_advances, mismatches);
    if (mismatches == 0) begin
      $display("mwc_random_with_hashed_seed_core_tb: PASS");
    end else begin
      $display("mwc_random_with_hashed_seed_core_tb: FAIL");
    end
    $finish;
  end

endmodule
